### rtl/dsha_pkg.sv
package dsha_pkg;

	typedef struct packed {
		logic [63:0] chunk_word_7;
		logic [63:0] chunk_word_6;
		logic [63:0] chunk_word_5;
		logic [63:0] chunk_word_4;
		logic [63:0] chunk_word_3;
		logic [63:0] chunk_word_2;
		logic [63:0] chunk_word_1;
		logic [63:0] chunk_word_0;
		logic [63:0] tail_high;
		logic [31:0] tail_low;
		logic [31:0] start_nonce;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_3;
		logic [63:0] digest_2;
		logic [63:0] digest_1;
		logic [63:0] digest_0;
	} out_item_t;

	typedef logic [7:0][31:0] state_t;
	typedef logic [15:0][31:0] block_t;

	localparam int Rounds = 64;

	localparam logic [63:0][31:0] RoundK = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
	};

	localparam state_t InitH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] PadWord   = 32'h80000000;
	localparam logic [31:0] TailBits  = 32'd640;
	localparam logic [31:0] DigestBits = 32'd256;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

### rtl/double_sha256_nonce_sweep.sv
// Channel  Ports                       Handshake
// in       start, busy, in_item        taken when start && !busy
// out      done, out_item              one-cycle strobe, no back-pressure
// Three chained 64-round compressions plus a nonce stage and an output register;
// one header accepted every cycle (busy stays low).
// Each round is one register stage; valid bits travel with the data.
// Reset clears the valid bits only; data in flight is dropped.
module double_sha256_nonce_sweep #(
	parameter int NONCE_SWEEP = 100
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  dsha_pkg::in_item_t    in_item,
	output logic                  done,
	output dsha_pkg::out_item_t   out_item
);
	import dsha_pkg::*;

	localparam logic [31:0] NonceOff = 32'(NONCE_SWEEP - 1);

	block_t blk2, blk3;
	state_t mid, st, fin;
	logic   v1, v2, v3;
	logic   tv_s1;
	logic [95:0] tail_s1;
	logic [31:0] nonce_s1;
	logic [127:0] tailn_m;
	block_t blk1_s1;

	assign busy = 1'b0;

	logic [511:0] hdr;
	assign hdr = {in_item.chunk_word_7, in_item.chunk_word_6, in_item.chunk_word_5,
		in_item.chunk_word_4, in_item.chunk_word_3, in_item.chunk_word_2,
		in_item.chunk_word_1, in_item.chunk_word_0};

	block_t blk1w;
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blk1w[i] = hdr[511 - 32*i -: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
		end else begin
			tv_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		tail_s1 <= {in_item.tail_high, in_item.tail_low};
		nonce_s1 <= bswap(bswap(in_item.start_nonce) + NonceOff);
	end

	always_ff @(posedge clk) begin
		blk1_s1 <= blk1w;
	end

	dsha_compress #(.SIDE_W(128)) u_mid (
		.clk(clk), .arst_n(arst_n), .vld(tv_s1), .init(InitH),
		.blk(blk1_s1), .side({tail_s1, nonce_s1}),
		.vld_o(v1), .hash(mid), .side_o(tailn_m)
	);

	always_comb begin
		blk2 = '0;
		blk2[0] = tailn_m[127:96];
		blk2[1] = tailn_m[95:64];
		blk2[2] = tailn_m[63:32];
		blk2[3] = tailn_m[31:0];
		blk2[4] = PadWord;
		blk2[15] = TailBits;
	end

	dsha_compress #(.SIDE_W(1)) u_tail (
		.clk(clk), .arst_n(arst_n), .vld(v1), .init(mid),
		.blk(blk2), .side(1'b0), .vld_o(v2), .hash(st), .side_o()
	);

	always_comb begin
		blk3 = '0;
		for (int i = 0; i < 8; i++) begin
			blk3[i] = st[i];
		end
		blk3[8] = PadWord;
		blk3[15] = DigestBits;
	end

	dsha_compress #(.SIDE_W(1)) u_fin (
		.clk(clk), .arst_n(arst_n), .vld(v2), .init(InitH),
		.blk(blk3), .side(1'b0), .vld_o(v3), .hash(fin), .side_o()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v3;
		end
	end

	always_ff @(posedge clk) begin
		out_item <= {fin[0], fin[1], fin[2], fin[3], fin[4], fin[5], fin[6], fin[7]};
	end

endmodule

### rtl/dsha_round.sv
module dsha_round #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  dsha_pkg::state_t      init,
	input  dsha_pkg::state_t      v,
	input  dsha_pkg::block_t      w,
	output logic                  vld_s1,
	output dsha_pkg::state_t      init_s1,
	output dsha_pkg::state_t      v_s1,
	output dsha_pkg::block_t      w_s1
);
	import dsha_pkg::*;

	logic [31:0] s0, s1, t1, t2, e, a, wn;

	always_comb begin
		e = v[4];
		a = v[0];
		t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v[5]) ^ (~e & v[6])) + RoundK[IDX] + w[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
		s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
		s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
		wn = s1 + w[9] + s0 + w[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		init_s1 <= init;
		v_s1 <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
		w_s1 <= {wn, w[15:1]};
	end

endmodule

### rtl/dsha_compress.sv
module dsha_compress #(
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  dsha_pkg::state_t      init,
	input  dsha_pkg::block_t      blk,
	input  logic [SIDE_W-1:0]     side,
	output logic                  vld_o,
	output dsha_pkg::state_t      hash,
	output logic [SIDE_W-1:0]     side_o
);
	import dsha_pkg::*;

	logic   [Rounds:0]       vld_p;
	state_t [Rounds:0]       init_p;
	state_t [Rounds:0]       v_p;
	block_t [Rounds:0]       w_p;
	logic   [Rounds:0][SIDE_W-1:0] side_p;

	assign vld_p[0] = vld;
	assign init_p[0] = init;
	assign v_p[0] = init;
	assign w_p[0] = blk;
	assign side_p[0] = side;

	for (genvar r = 0; r < Rounds; r++) begin : g_rnd
		dsha_round #(.IDX(r)) u_rnd (
			.clk(clk), .arst_n(arst_n), .vld(vld_p[r]),
			.init(init_p[r]), .v(v_p[r]), .w(w_p[r]),
			.vld_s1(vld_p[r+1]), .init_s1(init_p[r+1]),
			.v_s1(v_p[r+1]), .w_s1(w_p[r+1])
		);
		always_ff @(posedge clk) begin
			side_p[r+1] <= side_p[r];
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash[i] = init_p[Rounds][i] + v_p[Rounds][i];
		end
	end

	assign vld_o = vld_p[Rounds];
	assign side_o = side_p[Rounds];

endmodule
